@@ rtl/core/tcpc_pkg.sv @@
// ----------------------------------------------------------------------------
// tcpc_pkg
// Shared types and constants of the text console put-char block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpc_pkg;

    // cell layout: attribute in the high byte, character in the low byte
    localparam int CELL_W   = 16;
    localparam int CURSOR_W = 11;

    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
    localparam logic [7:0]        DEFAULT_ATTR = 8'h07;
    localparam logic [7:0]        SPACE_CHAR   = 8'h20;

    // control characters
    localparam logic [7:0] KEY_BACKSPACE = 8'd8;
    localparam logic [7:0] KEY_NEWLINE   = 8'd10;
    localparam logic [7:0] KEY_RETURN    = 8'd13;

    // item opcodes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL
    } state_t;

    // screen memory port controls
    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

endpackage : tcpc_pkg

`default_nettype wire

@@ rtl/core/text_console_put_char.sv @@
// ----------------------------------------------------------------------------
// text_console_put_char
// Text-mode screen store with cursor, control characters and scrolling.
// ----------------------------------------------------------------------------
//
//   channel   handshake         payload
//   -------   ---------------   -------------------------------------------
//   item in   start / busy      opcode, char_code, attribute, cell_index
//   result    done (one cycle)  cursor_position, cell_char, cell_attribute
//
// - a plain put, backspace, newline or return: result in the cycle after accept
// - a read: accept, then the read state, then the result (registered memory read)
// - a put that runs off the end: the scroll state clears one row per
//   scroll through a rotating base row in the single memory port
// - after reset a clearing pass over all ROWS*COLUMNS cells (2000 by default)
//   holds busy high
// - the result cannot be stalled; busy is low whenever a new item may start
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_put_char #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic [7:0]                    char_code,
    input  logic [7:0]                    attribute,
    input  logic [10:0]                   cell_index,
    output logic                          done,
    output logic [tcpc_pkg::CURSOR_W-1:0] cursor_position,
    output logic [7:0]                    cell_char,
    output logic [7:0]                    cell_attribute
);
    import tcpc_pkg::*;

    localparam int SIZE = ROWS * COLUMNS;
    localparam int AW   = $clog2(SIZE);

    mem_ctl_t          mem_ctl;
    logic [AW-1:0]     mem_addr;
    logic [CELL_W-1:0] mem_wdata;
    logic [CELL_W-1:0] mem_rdata;

    // sequencer and cursor
    tcpc_ctrl #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .char_code       (char_code),
        .attribute       (attribute),
        .cell_index      (cell_index),
        .done            (done),
        .cursor_position (cursor_position),
        .cell_char       (cell_char),
        .cell_attribute  (cell_attribute),
        .mem_ctl         (mem_ctl),
        .mem_addr        (mem_addr),
        .mem_wdata       (mem_wdata),
        .mem_rdata       (mem_rdata)
    );

    // screen cell store
    tcpc_screen_ram #(
        .DEPTH (SIZE)
    ) u_ram (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule : text_console_put_char

`default_nettype wire

@@ rtl/core/tcpc_screen_ram.sv @@
// ----------------------------------------------------------------------------
// tcpc_screen_ram
// Single-port synchronous screen memory with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpc_screen_ram #(
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  tcpc_pkg::mem_ctl_t         ctl,
    input  logic [AW-1:0]              addr,
    input  logic [tcpc_pkg::CELL_W-1:0] wdata,
    output logic [tcpc_pkg::CELL_W-1:0] rdata
);
    import tcpc_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[addr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule : tcpc_screen_ram

`default_nettype wire

@@ rtl/core/tcpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcpc_ctrl
// Sequencer, cursor tracking and ring addressing of the screen memory.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpc_ctrl #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80,
    localparam int SIZE = ROWS * COLUMNS,
    localparam int AW   = $clog2(SIZE)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic [7:0]                    char_code,
    input  logic [7:0]                    attribute,
    input  logic [10:0]                   cell_index,
    output logic                          done,
    output logic [tcpc_pkg::CURSOR_W-1:0] cursor_position,
    output logic [7:0]                    cell_char,
    output logic [7:0]                    cell_attribute,
    output tcpc_pkg::mem_ctl_t            mem_ctl,
    output logic [AW-1:0]                 mem_addr,
    output logic [tcpc_pkg::CELL_W-1:0]   mem_wdata,
    input  logic [tcpc_pkg::CELL_W-1:0]   mem_rdata
);
    import tcpc_pkg::*;

    localparam int CLW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int IW  = ((AW > 11) ? AW : 11) + 1;

    localparam logic [AW:0]    SIZE_X    = (AW+1)'(SIZE);
    localparam logic [AW:0]    COLS_X    = (AW+1)'(COLUMNS);
    localparam logic [AW-1:0]  LAST_CELL = AW'(SIZE - 1);
    localparam logic [AW-1:0]  LAST_COL  = AW'(COLUMNS - 1);
    localparam logic [CLW-1:0] COL_MAX   = CLW'(COLUMNS - 1);
    localparam logic [CLW:0]   COLS_C    = (CLW+1)'(COLUMNS);

    state_t          state_reg, state_next;
    logic [AW-1:0]   cursor_reg, cursor_next;
    logic [CLW-1:0]  col_reg, col_next;
    logic [AW-1:0]   base_reg, base_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic            done_reg, done_next;
    logic            in_range_reg, in_range_next;
    logic [7:0]      char_reg, char_next;
    logic [7:0]      attr_reg, attr_next;

    logic              accept;
    logic [7:0]        eff_attr;
    logic              put_we;
    logic [AW-1:0]     put_lin;
    logic [CELL_W-1:0] put_data;
    logic [AW:0]       cur_new;
    logic [CLW-1:0]    col_new;
    logic [CLW:0]      col_inc;
    logic              scroll;
    logic [IW-1:0]     idx_x;
    logic              idx_in_range;
    logic [AW-1:0]     lin_sel, off_sel;
    logic [AW:0]       addr_sum, addr_wrap;
    logic [AW:0]       cur_x, base_sum;
    logic [AW:0]       cur_less;
    logic [IW-1:0]     cur_out;

    assign accept       = start && !busy;
    assign eff_attr     = (attribute == 8'd0) ? DEFAULT_ATTR : attribute;
    assign idx_x        = IW'(cell_index);
    assign idx_in_range = idx_x < IW'(SIZE);
    assign cur_x        = {1'b0, cursor_reg};
    assign col_inc      = {1'b0, col_reg} + (CLW+1)'(1);
    assign scroll       = (cur_new == SIZE_X);
    assign cur_less     = cur_new - COLS_X;
    assign base_sum     = {1'b0, base_reg} + COLS_X;

    // put decode: cell write and cursor move
    always_comb
    begin
        put_we   = 1'b0;
        put_lin  = cursor_reg;
        put_data = {eff_attr, char_code};
        cur_new  = cur_x;
        col_new  = col_reg;
        case (char_code)
            KEY_BACKSPACE:
            begin
                if (cursor_reg != '0)
                begin
                    put_we   = 1'b1;
                    put_lin  = cursor_reg - AW'(1);
                    put_data = {eff_attr, SPACE_CHAR};
                    cur_new  = cur_x - (AW+1)'(1);
                    col_new  = (col_reg == '0) ? COL_MAX : col_reg - CLW'(1);
                end
            end
            KEY_NEWLINE:
            begin
                cur_new = cur_x + COLS_X - (AW+1)'(col_reg);
                col_new = '0;
            end
            KEY_RETURN:
            begin
                cur_new = cur_x - (AW+1)'(col_reg);
                col_new = '0;
            end
            default:
            begin
                put_we  = 1'b1;
                cur_new = cur_x + (AW+1)'(1);
                col_new = (col_inc == COLS_C) ? '0 : col_inc[CLW-1:0];
            end
        endcase
    end

    // ring addressing: logical cell plus rotating base, modulo screen size
    always_comb
    begin
        case (state_reg)
            ST_CLEAR:
            begin
                lin_sel = cnt_reg;
                off_sel = '0;
            end
            ST_SCROLL:
            begin
                lin_sel = cnt_reg;
                off_sel = base_reg;
            end
            default:
            begin
                lin_sel = (opcode == OP_READ) ? idx_x[AW-1:0] : put_lin;
                off_sel = base_reg;
            end
        endcase
        addr_sum  = {1'b0, lin_sel} + {1'b0, off_sel};
        addr_wrap = (addr_sum >= SIZE_X) ? addr_sum - SIZE_X : addr_sum;
        mem_addr  = addr_wrap[AW-1:0];
        mem_wdata = (state_reg == ST_IDLE) ? put_data : BLANK_CELL;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (scroll)
                    begin
                        state_next = ST_SCROLL;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_SCROLL:
            begin
                if (cnt_reg == LAST_COL)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: handshake and memory controls
    always_comb
    begin
        busy       = (state_reg != ST_IDLE);
        mem_ctl.we = 1'b0;
        mem_ctl.re = 1'b0;
        case (state_reg)
            ST_CLEAR, ST_SCROLL:
            begin
                mem_ctl.we = 1'b1;
            end
            ST_IDLE:
            begin
                mem_ctl.we = start && (opcode == OP_PUT) && put_we;
                mem_ctl.re = start && (opcode == OP_READ) && idx_in_range;
            end
            default:
            begin
                mem_ctl.we = 1'b0;
            end
        endcase
    end

    // register next values
    always_comb
    begin
        cursor_next   = cursor_reg;
        col_next      = col_reg;
        base_next     = base_reg;
        cnt_next      = cnt_reg;
        done_next     = 1'b0;
        in_range_next = in_range_reg;
        char_next     = char_reg;
        attr_next     = attr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = (cnt_reg == LAST_CELL) ? '0 : cnt_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_READ)
                    begin
                        in_range_next = idx_in_range;
                    end
                    else
                    begin
                        cursor_next = scroll ? cur_less[AW-1:0] : cur_new[AW-1:0];
                        col_next    = col_new;
                        char_next   = 8'd0;
                        attr_next   = 8'd0;
                        done_next   = !scroll;
                        cnt_next    = '0;
                    end
                end
            end
            ST_READ:
            begin
                char_next = in_range_reg ? mem_rdata[7:0] : 8'd0;
                attr_next = in_range_reg ? mem_rdata[15:8] : 8'd0;
                done_next = 1'b1;
            end
            ST_SCROLL:
            begin
                if (cnt_reg == LAST_COL)
                begin
                    cnt_next  = '0;
                    base_next = (base_sum == SIZE_X) ? '0 : base_sum[AW-1:0];
                    done_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cursor_reg <= '0;
            col_reg    <= '0;
            base_reg   <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            base_reg   <= base_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        in_range_reg <= in_range_next;
        char_reg     <= char_next;
        attr_reg     <= attr_next;
    end

    assign cur_out         = IW'(cursor_reg);
    assign cursor_position = cur_out[CURSOR_W-1:0];
    assign done            = done_reg;
    assign cell_char       = char_reg;
    assign cell_attribute  = attr_reg;

`ifndef ASSERT_OFF
    // cursor stays on screen once an item settles
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ({1'b0, cursor_reg} < SIZE_X))
        else $error("cursor left the screen");

    // column tracker stays in step with the row length
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= COL_MAX))
        else $error("column out of range");

    // no read and write of the memory in the same cycle
    a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.we && mem_ctl.re))
        else $error("memory read and write collide");

    // an accepted read item waits in the read state for the memory
    a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_READ)) |=> (state_reg == ST_READ))
        else $error("read item did not enter read state");

    // no result while the screen is being cleared
    a_no_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !done_reg)
        else $error("result during clearing pass");
`endif

endmodule : tcpc_ctrl

`default_nettype wire

@@ tb/text_console_checker.sv @@
// ----------------------------------------------------------------------------
// text_console_checker
// Watches the item and result channels of the text console, keeps its own
// copy of the screen and cursor, and compares every result with the
// prediction for the oldest accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_checker #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        opcode,
    input  wire logic [7:0]  char_code,
    input  wire logic [7:0]  attribute,
    input  wire logic [10:0] cell_index,
    input  wire logic        done,
    input  wire logic [10:0] cursor_position,
    input  wire logic [7:0]  cell_char,
    input  wire logic [7:0]  cell_attribute,
    output int               err_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcpc_pkg::*;

    localparam int SCREEN_CELLS = ROWS * COLUMNS;

    typedef struct packed {
        logic [10:0] cursor;
        logic [7:0]  ch;
        logic [7:0]  attr;
    } console_result_t;

    console_result_t    expected_results[$];
    logic [CELL_W-1:0]  screen_copy[SCREEN_CELLS];
    int unsigned        cursor_copy;

    // shift the screen up one row once the cursor runs off the end
    function automatic void scroll_screen();
        if (cursor_copy < SCREEN_CELLS)
            return;
        for (int i = 0; i < SCREEN_CELLS - COLUMNS; i++)
            screen_copy[i] = screen_copy[i + COLUMNS];
        for (int i = SCREEN_CELLS - COLUMNS; i < SCREEN_CELLS; i++)
            screen_copy[i] = BLANK_CELL;
        cursor_copy -= COLUMNS;
    endfunction

    // apply one item to the screen copy and return the result it gives
    function automatic console_result_t console_step(
        input logic        op,
        input logic [7:0]  ch,
        input logic [7:0]  attr,
        input logic [10:0] idx
    );
        console_result_t res;
        logic [7:0]      eff_attr;
        res = '0;
        eff_attr = (attr == 8'd0) ? DEFAULT_ATTR : attr;
        if (op == OP_READ)
        begin
            if (idx < SCREEN_CELLS)
            begin
                res.ch   = screen_copy[idx][7:0];
                res.attr = screen_copy[idx][15:8];
            end
        end
        else
        begin
            if (ch == KEY_BACKSPACE)
            begin
                if (cursor_copy > 0)
                begin
                    cursor_copy--;
                    screen_copy[cursor_copy] = {eff_attr, SPACE_CHAR};
                end
            end
            else if (ch == KEY_NEWLINE)
                cursor_copy = (cursor_copy / COLUMNS + 1) * COLUMNS;
            else if (ch == KEY_RETURN)
                cursor_copy = (cursor_copy / COLUMNS) * COLUMNS;
            else
            begin
                screen_copy[cursor_copy] = {eff_attr, ch};
                cursor_copy++;
            end
            scroll_screen();
        end
        res.cursor = cursor_copy[10:0];
        return res;
    endfunction

    // report the first few failures in full, count the rest
    function automatic void note_failure(input string what);
        err_count++;
        if (err_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // predict on each accepted item, compare on each result strobe
    always @(posedge clk or negedge rst_n)
    begin
        console_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SCREEN_CELLS; i++)
                screen_copy[i] = BLANK_CELL;
            cursor_copy = 0;
            expected_results.delete();
            err_count = 0;
        end
        else
        begin
            if (start && !busy)
                expected_results.push_back(
                    console_step(opcode, char_code, attribute, cell_index));
            if (done)
            begin
                if (expected_results.size() == 0)
                    note_failure($sformatf("result with no item pending: cur=%0d ch=%02h attr=%02h",
                                           cursor_position, cell_char, cell_attribute));
                else
                begin
                    want = expected_results.pop_front();
                    if (cursor_position !== want.cursor)
                        note_failure($sformatf("cursor_position exp %0d got %0d",
                                               want.cursor, cursor_position));
                    if (cell_char !== want.ch)
                        note_failure($sformatf("cell_char exp %02h got %02h",
                                               want.ch, cell_char));
                    if (cell_attribute !== want.attr)
                        note_failure($sformatf("cell_attribute exp %02h got %02h",
                                               want.attr, cell_attribute));
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

`default_nettype wire

@@ tb/tb_text_console_put_char.sv @@
// ----------------------------------------------------------------------------
// tb_text_console_put_char
// Drives put and read items into the text console: a directed pass over
// control characters, default attribute and read edges, then a long random
// run of text with newlines, backspaces and reads that scrolls the screen
// many times. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_text_console_put_char;
    timeunit 1ns;
    timeprecision 1ps;

    import tcpc_pkg::*;

    localparam int ROWS         = 25;
    localparam int COLUMNS      = 80;
    localparam int SCREEN_CELLS = ROWS * COLUMNS;
    localparam int RANDOM_ITEMS = 1620;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        opcode;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [10:0] cell_index;
    logic        done;
    logic [10:0] cursor_position;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attribute;

    int          err_count;
    int          pending;
    int          no_idle_left;
    logic [10:0] last_cursor;

    text_console_put_char #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .char_code       (char_code),
        .attribute       (attribute),
        .cell_index      (cell_index),
        .done            (done),
        .cursor_position (cursor_position),
        .cell_char       (cell_char),
        .cell_attribute  (cell_attribute)
    );

    text_console_checker #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) console_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .char_code       (char_code),
        .attribute       (attribute),
        .cell_index      (cell_index),
        .done            (done),
        .cursor_position (cursor_position),
        .cell_char       (cell_char),
        .cell_attribute  (cell_attribute),
        .err_count       (err_count),
        .pending         (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // cursor seen in the latest result, used to aim reads near fresh text
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_cursor <= '0;
        else if (done)
            last_cursor <= cursor_position;
    end

    // hold one item on the inputs until the block takes it
    task automatic send_item(
        input logic        op,
        input logic [7:0]  ch,
        input logic [7:0]  attr,
        input logic [10:0] idx
    );
        @(negedge clk);
        start      = 1'b1;
        opcode     = op;
        char_code  = ch;
        attribute  = attr;
        cell_index = idx;
        do
            @(posedge clk);
        while (busy);
    endtask

    // random gap after an item: mostly none or short, a few long
    task automatic idle_gap();
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (no_idle_left > 0)
        begin
            no_idle_left--;
            gap = 0;
        end
        else if (pick < 3)
        begin
            no_idle_left = $urandom_range(30, 80);
            gap = 0;
        end
        else if (pick < 55)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic put_char(input logic [7:0] ch, input logic [7:0] attr);
        send_item(OP_PUT, ch, attr, 11'($urandom_range(0, 2047)));
        idle_gap();
    endtask

    task automatic read_cell(input logic [10:0] idx);
        send_item(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), idx);
        idle_gap();
    endtask

    // attribute with the default selector showing up often
    function automatic logic [7:0] pick_attr();
        if ($urandom_range(0, 5) == 0)
            return 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    // one random item shaped like console traffic
    task automatic send_random_item();
        int pick;
        int near;
        pick = $urandom_range(0, 99);
        if (pick < 52)
            put_char(8'($urandom_range(0, 255)), pick_attr());
        else if (pick < 60)
            put_char(KEY_NEWLINE, pick_attr());
        else if (pick < 63)
            put_char(KEY_RETURN, pick_attr());
        else if (pick < 70)
            put_char(KEY_BACKSPACE, pick_attr());
        else if (pick < 82)
        begin
            near = int'(last_cursor) - int'($urandom_range(0, 90));
            read_cell((near < 0) ? 11'd0 : near[10:0]);
        end
        else if (pick < 90)
            read_cell(11'($urandom_range(0, SCREEN_CELLS - 1)));
        else if (pick < 95)
            read_cell(11'($urandom_range(SCREEN_CELLS - COLUMNS, SCREEN_CELLS - 1)));
        else
            read_cell(11'($urandom_range(0, 2047)));
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = OP_PUT;
        char_code    = '0;
        attribute    = '0;
        cell_index   = '0;
        no_idle_left = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // read edges on the freshly cleared screen
        read_cell(11'd0);
        read_cell(11'd1999);
        read_cell(11'd2000);
        read_cell(11'd2047);

        // backspace at the first cell does nothing
        put_char(KEY_BACKSPACE, 8'd0);

        // plain characters, default attribute and byte extremes
        put_char("H", 8'd0);
        put_char(8'h00, 8'hFF);
        put_char(8'hFF, 8'h80);
        put_char(8'h7F, 8'h01);
        read_cell(11'd0);
        read_cell(11'd1);
        read_cell(11'd2);

        // backspace elsewhere blanks the cell with the given attribute
        put_char(KEY_BACKSPACE, 8'd0);
        put_char(KEY_BACKSPACE, 8'hA5);
        read_cell(11'd1);
        read_cell(11'd2);

        // carriage return and newline
        put_char("x", 8'h3C);
        put_char(KEY_RETURN, 8'd0);
        put_char(KEY_NEWLINE, 8'h00);
        put_char("y", 8'h1E);
        read_cell(11'd80);
        read_cell(11'd0);

        // newlines down past the last row force a scroll by newline
        repeat (25) put_char(KEY_NEWLINE, pick_attr());
        read_cell(11'd0);

        // a full row of text runs off the end and scrolls by character
        repeat (COLUMNS + 3) put_char(8'($urandom_range(32, 126)), pick_attr());
        read_cell(11'(SCREEN_CELLS - COLUMNS - 1));
        read_cell(11'(SCREEN_CELLS - 1));

        // random console traffic
        repeat (RANDOM_ITEMS) send_random_item();

        @(negedge clk);
        start = 1'b0;
        wait (pending == 0);
        repeat (COLUMNS + 20) @(posedge clk);
        if (err_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // overall time limit
    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
